>>> rtl/mt_rng_pkg.sv
`timescale 1ns / 1ps
package mt_rng_pkg;

	localparam logic [1:0] MODE_SEED = 2'd0;
	localparam logic [1:0] MODE_RAW  = 2'd1;
	localparam logic [1:0] MODE_EXCL = 2'd2;
	localparam logic [1:0] MODE_INCL = 2'd3;

	localparam int unsigned TWIST_OFFSET = 397;
	localparam logic [31:0] MATRIX_A   = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
	localparam logic [31:0] SEED_MULT  = 32'd1812433253;
	localparam logic [31:0] ALL_ONES   = 32'hffff_ffff;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_LIMDIV,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_EVAL,
		ST_MODDIV,
		ST_OUT
	} state_t;

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

>>> rtl/mt_rng_ram.sv
`timescale 1ns / 1ps
module mt_rng_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/mt19937_ranged_generator.sv
`timescale 1ns / 1ps
// MT19937 generator with range draws. One input beat gives one output beat.
// Mode 0 reseeds: the 624 state words are written one per cycle (the seed
// multiplier recurrence), and a reseed returns 0. A draw must not be
// issued before the first reseed. Mode 1 returns one tempered word: the
// state RAM has one read port, so the three words of the twist (current,
// next, far) are read one after another in RD0, RD1 and RD2 and the new
// word is written back in RD3. Modes 2 and 3 return a value in
// [low_bound, high_bound) or [low_bound, high_bound]; they first compute
// 0xFFFFFFFF mod size with a bit-serial divider, then draw words until one
// falls below the rejection limit, then take that word mod size. Equal
// bounds return low_bound (in mode 2 without a draw), and mode 3 over the
// full 32-bit range returns a plain tempered word.
// The next beat is accepted once the current one has moved to the output
// register, even if that register is still stalled.
module mt19937_ranged_generator #(
	parameter int STATE_WORDS = 624
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] seed_value,
	input  logic [31:0] low_bound,
	input  logic [31:0] high_bound,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] random_word
);

	localparam int AW = $clog2(STATE_WORDS);
	localparam logic [AW-1:0] LAST_IDX = AW'(STATE_WORDS - 1);

	mt_rng_pkg::state_t state_q, state_d;

	// ring position and per-item registers
	logic [AW-1:0] pos_q;
	logic [AW-1:0] seed_idx_q;
	logic [31:0]   seed_v_q;
	logic          is_raw_q;
	logic [31:0]   base_q;
	logic [31:0]   size_q;
	logic [31:0]   limit_q;
	logic          msb_q;
	logic [30:0]   low_bits_q;
	logic [31:0]   draw_q;
	logic [31:0]   res_q;
	logic [31:0]   dvd_q;
	logic [31:0]   rem_q;
	logic [4:0]    div_cnt_q;
	logic          out_valid_q;
	logic [31:0]   out_word_q;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	mt_rng_ram #(
		.WIDTH(32),
		.DEPTH(STATE_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ring neighbors
	logic [AW-1:0] pos_next;
	logic [AW:0]   far_sum;
	logic [AW-1:0] pos_far;

	assign pos_next = (pos_q == LAST_IDX) ? '0 : pos_q + AW'(1);
	assign far_sum  = {1'b0, pos_q} + (AW+1)'(mt_rng_pkg::TWIST_OFFSET);
	assign pos_far  = (far_sum >= (AW+1)'(STATE_WORDS)) ?
		AW'(far_sum - (AW+1)'(STATE_WORDS)) : far_sum[AW-1:0];

	// twist of the current word
	logic [31:0] twist_x;
	logic [31:0] twist_xa;
	logic [31:0] twist_new;

	assign twist_x   = {msb_q, low_bits_q};
	assign twist_xa  = (twist_x >> 1) ^ (twist_x[0] ? mt_rng_pkg::MATRIX_A : 32'd0);
	assign twist_new = ram_rdata ^ twist_xa;

	// seed recurrence: one word per cycle
	logic [31:0] seed_mix;
	logic [63:0] seed_prod;
	logic [31:0] seed_next;

	assign seed_mix  = seed_v_q ^ (seed_v_q >> 30);
	assign seed_prod = 64'(seed_mix) * 64'(mt_rng_pkg::SEED_MULT);
	assign seed_next = seed_prod[31:0] + 32'(seed_idx_q) + 32'd1;

	// bit-serial restoring divider step
	logic [32:0] div_shift;
	logic [32:0] div_trial;
	logic [31:0] div_rem_next;

	assign div_shift    = {rem_q, dvd_q[31]};
	assign div_trial    = div_shift - {1'b0, size_q};
	assign div_rem_next = div_trial[32] ? div_shift[31:0] : div_trial[31:0];

	// range setup at accept
	logic        top_case;
	logic [31:0] rng_lo;
	logic [31:0] rng_hi;
	logic [31:0] rng_min;
	logic [31:0] rng_max;

	always_comb begin
		top_case = (mode == mt_rng_pkg::MODE_INCL) && (high_bound == mt_rng_pkg::ALL_ONES);
		rng_lo   = low_bound;
		rng_hi   = (mode == mt_rng_pkg::MODE_INCL) ? high_bound + 32'd1 : high_bound;
		rng_min  = (rng_lo > rng_hi) ? rng_hi : rng_lo;
		rng_max  = (rng_lo > rng_hi) ? rng_lo : rng_hi;
	end

	logic accept_in;
	logic out_free;

	assign accept_in = in_valid && (state_q == mt_rng_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != mt_rng_pkg::ST_IDLE);
	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = twist_new;
		ram_raddr = pos_q;
		case (state_q)
			mt_rng_pkg::ST_IDLE: begin
				if (accept_in) begin
					case (mode)
						mt_rng_pkg::MODE_SEED: state_d = mt_rng_pkg::ST_SEED;
						mt_rng_pkg::MODE_RAW:  state_d = mt_rng_pkg::ST_RD0;
						default: begin
							if (top_case) begin
								state_d = (low_bound == 32'd0) ?
									mt_rng_pkg::ST_RD0 : mt_rng_pkg::ST_LIMDIV;
							end else if (rng_min == rng_max) begin
								state_d = mt_rng_pkg::ST_OUT;
							end else begin
								state_d = mt_rng_pkg::ST_LIMDIV;
							end
						end
					endcase
				end
			end
			mt_rng_pkg::ST_SEED: begin
				ram_we    = 1'b1;
				ram_waddr = seed_idx_q;
				ram_wdata = seed_v_q;
				if (seed_idx_q == LAST_IDX) begin
					state_d = mt_rng_pkg::ST_OUT;
				end
			end
			mt_rng_pkg::ST_LIMDIV: begin
				if (div_cnt_q == 5'd31) begin
					state_d = mt_rng_pkg::ST_RD0;
				end
			end
			mt_rng_pkg::ST_RD0: begin
				ram_raddr = pos_q;
				state_d   = mt_rng_pkg::ST_RD1;
			end
			mt_rng_pkg::ST_RD1: begin
				ram_raddr = pos_next;
				state_d   = mt_rng_pkg::ST_RD2;
			end
			mt_rng_pkg::ST_RD2: begin
				ram_raddr = pos_far;
				state_d   = mt_rng_pkg::ST_RD3;
			end
			mt_rng_pkg::ST_RD3: begin
				ram_we  = 1'b1;
				state_d = mt_rng_pkg::ST_EVAL;
			end
			mt_rng_pkg::ST_EVAL: begin
				if (is_raw_q) begin
					state_d = mt_rng_pkg::ST_OUT;
				end else if (draw_q >= limit_q) begin
					state_d = mt_rng_pkg::ST_RD0;
				end else begin
					state_d = mt_rng_pkg::ST_MODDIV;
				end
			end
			mt_rng_pkg::ST_MODDIV: begin
				if (div_cnt_q == 5'd31) begin
					state_d = mt_rng_pkg::ST_OUT;
				end
			end
			mt_rng_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = mt_rng_pkg::ST_IDLE;
				end
			end
			default: state_d = mt_rng_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mt_rng_pkg::ST_IDLE;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mt_rng_pkg::ST_SEED && seed_idx_q == LAST_IDX) begin
				pos_q <= '0;
			end else if (state_q == mt_rng_pkg::ST_RD3) begin
				pos_q <= pos_next;
			end
			if (state_q == mt_rng_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			mt_rng_pkg::ST_IDLE: begin
				seed_idx_q <= '0;
				seed_v_q   <= seed_value;
				res_q      <= 32'd0;
				div_cnt_q  <= '0;
				rem_q      <= '0;
				dvd_q      <= mt_rng_pkg::ALL_ONES;
				is_raw_q   <= (mode == mt_rng_pkg::MODE_RAW) ||
					(top_case && low_bound == 32'd0);
				if (top_case) begin
					base_q <= low_bound;
					size_q <= 32'd0 - low_bound;
				end else begin
					base_q <= rng_min;
					size_q <= rng_max - rng_min;
					// reseed answers 0; equal bounds answer the low bound
					res_q  <= (mode == mt_rng_pkg::MODE_SEED) ? 32'd0 : rng_min;
				end
			end
			mt_rng_pkg::ST_SEED: begin
				seed_idx_q <= seed_idx_q + AW'(1);
				seed_v_q   <= seed_next;
			end
			mt_rng_pkg::ST_LIMDIV: begin
				rem_q     <= div_rem_next;
				dvd_q     <= {dvd_q[30:0], 1'b0};
				div_cnt_q <= div_cnt_q + 5'd1;
				if (div_cnt_q == 5'd31) begin
					limit_q <= mt_rng_pkg::ALL_ONES - div_rem_next;
				end
			end
			mt_rng_pkg::ST_RD1: begin
				msb_q <= ram_rdata[31];
			end
			mt_rng_pkg::ST_RD2: begin
				low_bits_q <= ram_rdata[30:0];
			end
			mt_rng_pkg::ST_RD3: begin
				draw_q <= mt_rng_pkg::temper(twist_new);
			end
			mt_rng_pkg::ST_EVAL: begin
				res_q     <= draw_q;
				dvd_q     <= draw_q;
				rem_q     <= '0;
				div_cnt_q <= '0;
			end
			mt_rng_pkg::ST_MODDIV: begin
				rem_q     <= div_rem_next;
				dvd_q     <= {dvd_q[30:0], 1'b0};
				div_cnt_q <= div_cnt_q + 5'd1;
				if (div_cnt_q == 5'd31) begin
					res_q <= base_q + div_rem_next;
				end
			end
			mt_rng_pkg::ST_OUT: begin
				if (out_free) begin
					out_word_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> dv/mt_rng_checker.sv
`timescale 1ns / 1ps
module mt_rng_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] seed_value,
	input  logic [31:0] low_bound,
	input  logic [31:0] high_bound,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] random_word,
	output int          fail_count,
	output int          words_pending
);

	logic [31:0] mt_state [624];
	int unsigned mt_idx;
	logic [31:0] expected_words [$];

	function automatic logic [31:0] next_tempered();
		int unsigned k, nx, fr;
		logic [31:0] x, xa, y;
		k = mt_idx;
		nx = (k + 1) % 624;
		fr = (k + mt_rng_pkg::TWIST_OFFSET) % 624;
		x = (mt_state[k] & 32'h8000_0000) | (mt_state[nx] & 32'h7fff_ffff);
		xa = x >> 1;
		if (x[0]) xa = xa ^ mt_rng_pkg::MATRIX_A;
		x = mt_state[fr] ^ xa;
		mt_state[k] = x;
		mt_idx = nx;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & mt_rng_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mt_rng_pkg::TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [31:0] bounded_draw(logic [31:0] lo, logic [31:0] hi);
		logic [31:0] t, sz, lim, v;
		if (lo > hi) begin
			t = lo; lo = hi; hi = t;
		end
		if (lo == hi) return lo;
		sz = hi - lo;
		lim = mt_rng_pkg::ALL_ONES - (mt_rng_pkg::ALL_ONES % sz);
		do v = next_tempered(); while (v >= lim);
		return lo + v % sz;
	endfunction

	function automatic logic [31:0] predict_word(logic [1:0] m, logic [31:0] sd,
			logic [31:0] lo, logic [31:0] hi);
		logic [31:0] v;
		case (m)
			mt_rng_pkg::MODE_SEED: begin
				v = sd;
				mt_state[0] = v;
				for (int i = 1; i < 624; i++) begin
					v = mt_rng_pkg::SEED_MULT * (v ^ (v >> 30)) + 32'(i);
					mt_state[i] = v;
				end
				mt_idx = 0;
				return 32'd0;
			end
			mt_rng_pkg::MODE_RAW: return next_tempered();
			mt_rng_pkg::MODE_EXCL: return bounded_draw(lo, hi);
			default: begin
				if (hi == mt_rng_pkg::ALL_ONES) begin
					if (lo == 0) return next_tempered();
					return lo + bounded_draw(32'd0, mt_rng_pkg::ALL_ONES - lo + 32'd1);
				end
				return bounded_draw(lo, hi + 32'd1);
			end
		endcase
	endfunction

	assign words_pending = expected_words.size();

	initial begin
		fail_count = 0;
		mt_idx = 0;
		foreach (mt_state[i]) mt_state[i] = '0;
	end

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected beat random_word=%h", random_word);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_words.pop_front();
					if (want !== random_word) begin
						$error("random_word expected %h actual %h", want, random_word);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_words.push_back(predict_word(mode, seed_value, low_bound,
					high_bound));
		end
	end
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  mode = mt_rng_pkg::MODE_SEED;
	logic [31:0] seed_value = 0;
	logic [31:0] low_bound = 0;
	logic [31:0] high_bound = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [31:0] random_word;
	int          fail_count;
	int          words_pending;
	int          cycle_count = 0;
	bit          long_hold = 0;    // receiver holds off while set
	bit          stall_free = 0;   // receiver never stalls while set

	always #5 clk = ~clk;

	mt19937_ranged_generator dut (.*);

	mt_rng_checker checker_i (.*);

	// watchdog: reports a fail and ends the run once cycle_count passes its limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stall pattern, stretches of no stall, one long hold
	always @(negedge clk) begin
		if (long_hold) out_stall <= 1'b1;
		else if (stall_free) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	function automatic logic [31:0] edge_word();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			2: return $urandom_range(0, 15);
			3: return 32'hffff_ffff - $urandom_range(0, 15);
			4: return 32'h8000_0000 ^ $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	// offer one beat at the falling edge and hold it until accepted
	task automatic send_beat(logic [1:0] m, logic [31:0] sd, logic [31:0] lo,
			logic [31:0] hi);
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= m;
		seed_value <= sd;
		low_bound <= lo;
		high_bound <= hi;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic idle_cycles(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		idle_cycles(1);
		while (words_pending != 0) @(negedge clk);
	endtask

	initial begin
		logic [1:0] m;
		int burst;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: seeds extremes, every mode, bound corner cases
		send_beat(mt_rng_pkg::MODE_SEED, 32'd0, 32'd0, 32'd0);
		send_beat(mt_rng_pkg::MODE_RAW, 32'd0, 32'd0, 32'd0);
		send_beat(mt_rng_pkg::MODE_SEED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_beat(mt_rng_pkg::MODE_RAW, 32'd0, 32'd0, 32'd0);
		send_beat(mt_rng_pkg::MODE_SEED, 32'd5489, 32'd0, 32'd0);
		send_beat(mt_rng_pkg::MODE_RAW, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_beat(mt_rng_pkg::MODE_EXCL, 0, 32'd10, 32'd20);
		send_beat(mt_rng_pkg::MODE_EXCL, 0, 32'd20, 32'd10);           // reversed
		send_beat(mt_rng_pkg::MODE_EXCL, 0, 32'd7, 32'd7);             // equal
		send_beat(mt_rng_pkg::MODE_EXCL, 0, 32'd0, 32'hffff_ffff);
		send_beat(mt_rng_pkg::MODE_EXCL, 0, 32'hffff_ffff, 32'd0);
		send_beat(mt_rng_pkg::MODE_EXCL, 0, 32'd0, 32'd1);
		send_beat(mt_rng_pkg::MODE_EXCL, 0, 32'd0, 32'h8000_0001);     // heavy rejection
		send_beat(mt_rng_pkg::MODE_INCL, 0, 32'd0, 32'hffff_ffff);     // full range
		send_beat(mt_rng_pkg::MODE_INCL, 0, 32'd1, 32'hffff_ffff);     // top-ended
		send_beat(mt_rng_pkg::MODE_INCL, 0, 32'hffff_ffff, 32'hffff_ffff);
		send_beat(mt_rng_pkg::MODE_INCL, 0, 32'd3, 32'd3);
		send_beat(mt_rng_pkg::MODE_INCL, 0, 32'd9, 32'd2);
		send_beat(mt_rng_pkg::MODE_INCL, 0, 32'hffff_fffe, 32'hffff_fffe);
		send_beat(mt_rng_pkg::MODE_INCL, 0, 32'd0, 32'hffff_fffe);
		send_beat(mt_rng_pkg::MODE_INCL, 0, 32'hffff_ffff, 32'hffff_fffe); // low = high+1

		// pause until all results are back
		drain();

		// receiver holds off while the sender keeps offering beats
		long_hold = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end
			for (int i = 0; i < 8; i++) send_beat(mt_rng_pkg::MODE_RAW, $urandom, 0, 0);
		join

		// random part: rare reseeds, mostly draws with mixed bounds
		for (int n = 0; n < 900; ) begin
			burst = $urandom_range(1, 12);
			stall_free = ($urandom_range(0, 4) == 0);
			for (int b = 0; b < burst && n < 900; b++, n++) begin
				m = ($urandom_range(0, 49) == 0) ? mt_rng_pkg::MODE_SEED :
					2'($urandom_range(1, 3));
				send_beat(m, $urandom, edge_word(), edge_word());
			end
			if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 40));
		end

		drain();
		stall_free = 1'b0;
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

>>> mt19937_ranged_generator.f
rtl/mt_rng_pkg.sv
rtl/mt_rng_ram.sv
rtl/mt19937_ranged_generator.sv
dv/mt_rng_checker.sv
dv/testbench.sv
